### rtl/psrm_pkg.sv
// Shared types, pattern constants and the tail-compare function of the signature matcher.
`default_nettype none

package psrm_pkg;

    // Depth of the byte window and the width of its flattened form.
    localparam int WINDOW_LEN = 15;
    localparam int WIN_BITS   = WINDOW_LEN * 8;

    localparam int NUM_PATH_PATS = 18;
    localparam int NUM_CMD_PATS  = 19;

    // Number of verdict bits in a result word.
    localparam int NUM_VERDICTS = 6;

    typedef logic [WIN_BITS-1:0]      win_t;
    typedef logic [NUM_PATH_PATS-1:0] path_hits_t;
    typedef logic [NUM_CMD_PATS-1:0]  cmd_hits_t;
    typedef logic [NUM_VERDICTS-1:0]  verdict_t;

    typedef enum logic [1:0] {
        ACT_PATH = 2'd0,
        ACT_CMD  = 2'd1,
        ACT_END  = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    // Verdict bit positions inside a result word.
    localparam int V_DD      = 0;
    localparam int V_GROUP   = 1;
    localparam int V_SENS    = 2;
    localparam int V_USER    = 3;
    localparam int V_HIST    = 4;
    localparam int V_ANY     = 5;

    // Hit-flag update request from the top level to the matcher.
    typedef struct packed {
        logic path_en;
        logic cmd_en;
        logic flush;
    } psrm_ctl_t;

    // Patterns are right-aligned: last character in the low byte, zero bytes above.
    localparam win_t PATH_PATS [NUM_PATH_PATS] = '{
        win_t'("/bin/dd"), win_t'("/usr/bin/dd"), win_t'("/groupdel"), win_t'("/userdel"),
        win_t'("/cat"), win_t'("/echo"), win_t'("/grep"), win_t'("/head"),
        win_t'("/more"), win_t'("/tail"),
        win_t'("/emacs"), win_t'("/nano"), win_t'("/sed"), win_t'("/vi"), win_t'("/vim"),
        win_t'("/rm"), win_t'("/unlink"), win_t'("/shred")
    };

    // Shell history file names are built from a shell prefix and a common suffix.
    localparam win_t CMD_PATS [NUM_CMD_PATS] = '{
        win_t'("of="), win_t'("if=/dev/zero"), win_t'("if=/dev/null"), win_t'(">"),
        win_t'("/bin/login"), win_t'("/bin/passwd"), win_t'("/boot/"),
        win_t'("/etc/*.conf"), win_t'("/etc/cron."), win_t'("/etc/crontab"),
        win_t'("/etc/hosts"), win_t'("/etc/init.d"), win_t'("/etc/sudoers"),
        win_t'("/opt/bin/"), win_t'("/sbin"), win_t'("/usr/bin/"),
        win_t'("/usr/local/bin/"), win_t'({"/.bash", "_history"}),
        win_t'({"/.zsh", "_history"})
    };

    // Compare the newest bytes of the window with a pattern; zero pattern bytes
    // lie past the pattern's start and are don't-care.
    function automatic logic tail_match(input win_t win, input win_t pat);
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < WINDOW_LEN; k++) begin
            if (pat[k*8 +: 8] != 8'h00 && win[k*8 +: 8] != pat[k*8 +: 8]) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

`default_nettype wire

### rtl/psrm_cell.sv
// One byte cell of the shifting character window.
`default_nettype none

module psrm_cell (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       shift,   // take the neighbor's byte
    input  wire logic       kill,    // take zero instead of the neighbor's byte
    input  wire logic       flush,   // clear at end of event
    input  wire logic [7:0] din,
    output logic      [7:0] dnext,
    output logic      [7:0] q
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = byte_reg;
        if (flush) begin
            byte_next = 8'h00;
        end else if (shift) begin
            byte_next = kill ? 8'h00 : din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            byte_reg <= 8'h00;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign dnext = byte_next;
    assign q     = byte_reg;

endmodule

`default_nettype wire

### rtl/psrm_match.sv
// Pattern comparators, sticky hit flags and rule verdicts.
`default_nettype none

module psrm_match (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire psrm_pkg::psrm_ctl_t ctl,
    input  wire psrm_pkg::win_t      win_next,
    output psrm_pkg::verdict_t       verdict
);

    psrm_pkg::path_hits_t path_hits_reg;
    psrm_pkg::path_hits_t path_hits_next;
    psrm_pkg::cmd_hits_t  cmd_hits_reg;
    psrm_pkg::cmd_hits_t  cmd_hits_next;
    psrm_pkg::path_hits_t path_now;
    psrm_pkg::cmd_hits_t  cmd_now;

    logic dd, grp, usr, reader, editor, redirect, sens_path, sens, remover, hist_file, hist;

    always_comb
    begin
        for (int k = 0; k < psrm_pkg::NUM_PATH_PATS; k++) begin
            path_now[k] = psrm_pkg::tail_match(win_next, psrm_pkg::PATH_PATS[k]);
        end
        for (int k = 0; k < psrm_pkg::NUM_CMD_PATS; k++) begin
            cmd_now[k] = psrm_pkg::tail_match(win_next, psrm_pkg::CMD_PATS[k]);
        end
    end

    always_comb
    begin
        path_hits_next = path_hits_reg;
        cmd_hits_next  = cmd_hits_reg;
        if (ctl.flush) begin
            path_hits_next = '0;
            cmd_hits_next  = '0;
        end else begin
            if (ctl.path_en) begin
                path_hits_next = path_hits_reg | path_now;
            end
            if (ctl.cmd_en) begin
                cmd_hits_next = cmd_hits_reg | cmd_now;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            path_hits_reg <= '0;
            cmd_hits_reg  <= '0;
        end else begin
            path_hits_reg <= path_hits_next;
            cmd_hits_reg  <= cmd_hits_next;
        end
    end

    always_comb
    begin
        dd        = (|path_hits_reg[1:0]) && cmd_hits_reg[0] && (|cmd_hits_reg[2:1]);
        grp       = path_hits_reg[2];
        usr       = path_hits_reg[3];
        reader    = |path_hits_reg[9:4];
        editor    = |path_hits_reg[14:10];
        redirect  = cmd_hits_reg[3];
        sens_path = |cmd_hits_reg[16:4];
        sens      = ((reader && redirect) || editor) && sens_path;
        remover   = |path_hits_reg[17:15];
        hist_file = |cmd_hits_reg[18:17];
        hist      = remover && hist_file;

        verdict                   = '0;
        verdict[psrm_pkg::V_DD]    = dd;
        verdict[psrm_pkg::V_GROUP] = grp;
        verdict[psrm_pkg::V_SENS]  = sens;
        verdict[psrm_pkg::V_USER]  = usr;
        verdict[psrm_pkg::V_HIST]  = hist;
        verdict[psrm_pkg::V_ANY]   = dd || grp || sens || usr || hist;
    end

endmodule

`default_nettype wire

### rtl/process_signature_rule_matcher_core.sv
// Top level of the process signature rule matcher: byte window, matcher and output register.
//
// Usage: one process event enters on the s_* channel as a run of words, one
// byte each: path bytes (s_tuser = path), then command-line bytes (s_tuser =
// command line), then one end-of-event word (s_tuser = end, s_tdata ignored).
// Words with the unused kind code are taken and dropped.
// Byte words produce no output. The end-of-event word produces one result
// word on m_* carrying the five rule verdicts and their OR.
// Throughput: one input word per cycle unless a result waits. Each byte shifts the
// row of window cells and its matches fold into the hit flags in the same
// cycle. Latency: the result word is valid in the cycle after the
// end-of-event word is accepted; the hit flags and window clear at that same
// edge, so the next event may start at once.
// Stall: the result sits in the output register until taken; input is held
// off (s_tready low) only while a result waits and m_tready is low.
// Reset: window, hit flags, last kind and the output valid all clear.
`default_nettype none

module process_signature_rule_matcher_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] char_byte
    input  wire logic [1:0] s_tuser,   // [1:0] action
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata    // [0] dd_overwrite, [1] group_deleted,
                                       // [2] sensitive_file_change, [3] user_deleted,
                                       // [4] history_deleted, [5] any_rule, [7:6] zero
);

    logic                 accept;
    logic                 byte_op;
    logic                 end_op;
    logic                 kind_change;
    logic                 last_kind_reg;
    logic                 last_kind_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    psrm_pkg::verdict_t   out_data_reg;
    psrm_pkg::verdict_t   verdict;
    psrm_pkg::psrm_ctl_t  ctl;
    psrm_pkg::win_t       win_next;
    logic [7:0]           cell_q [psrm_pkg::WINDOW_LEN];
    psrm_pkg::action_t    action;

    assign action   = psrm_pkg::action_t'(s_tuser);
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        byte_op = 1'b0;
        end_op  = 1'b0;
        if (accept) begin
            case (action)
                psrm_pkg::ACT_PATH: byte_op = 1'b1;
                psrm_pkg::ACT_CMD:  byte_op = 1'b1;
                psrm_pkg::ACT_END:  end_op  = 1'b1;
                default:            byte_op = 1'b0;
            endcase
        end
    end

    // A byte of the other kind wipes the window before it enters.
    assign kind_change = byte_op && (s_tuser[0] != last_kind_reg);

    always_comb
    begin
        last_kind_next = last_kind_reg;
        if (end_op) begin
            last_kind_next = 1'b0;
        end else if (byte_op) begin
            last_kind_next = s_tuser[0];
        end
    end

    assign ctl.path_en = byte_op && !s_tuser[0];
    assign ctl.cmd_en  = byte_op && s_tuser[0];
    assign ctl.flush   = end_op;

    // Row of window cells; cell 0 holds the newest byte.
    for (genvar k = 0; k < psrm_pkg::WINDOW_LEN; k++) begin : g_cell
        logic [7:0] din;
        logic [7:0] dnext;

        if (k == 0) begin : g_head
            assign din = s_tdata;
        end else begin : g_link
            assign din = cell_q[k-1];
        end

        psrm_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (byte_op),
            .kill  ((k != 0) && kind_change),
            .flush (end_op),
            .din   (din),
            .dnext (dnext),
            .q     (cell_q[k])
        );

        assign win_next[k*8 +: 8] = dnext;
    end

    psrm_match u_match (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .win_next (win_next),
        .verdict  (verdict)
    );

    // Load a result on end of event; drop valid once taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (end_op) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            last_kind_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            last_kind_reg <= last_kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (end_op) begin
            out_data_reg <= verdict;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_data_reg};

endmodule

`default_nettype wire

### tb/rule_verdict_checker.sv
// Checker for the signature matcher: predicts rule verdicts from accepted words and compares results.
`timescale 1ns / 1ps

module rule_verdict_checker
    import psrm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    input  wire logic       s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic [1:0] s_tuser,
    input  wire logic       m_tvalid,
    input  wire logic       m_tready,
    input  wire logic [7:0] m_tdata,
    output int              fail_count,
    output int              pending
);

    localparam int SPAN = 15;

    string path_pats [18] = '{
        "/bin/dd", "/usr/bin/dd", "/groupdel", "/userdel",
        "/cat", "/echo", "/grep", "/head", "/more", "/tail",
        "/emacs", "/nano", "/sed", "/vi", "/vim",
        "/rm", "/unlink", "/shred"
    };

    string cmd_pats [19] = '{
        "of=", "if=/dev/zero", "if=/dev/null", ">",
        "/bin/login", "/bin/passwd", "/boot/", "/etc/*.conf", "/etc/cron.",
        "/etc/crontab", "/etc/hosts", "/etc/init.d", "/etc/sudoers",
        "/opt/bin/", "/sbin", "/usr/bin/", "/usr/local/bin/",
        {"/.bash", "_history"}, {"/.zsh", "_history"}
    };

    string field_names [8] = '{
        "dd_overwrite", "group_deleted", "sensitive_file_change", "user_deleted",
        "history_deleted", "any_rule", "pad bit 6", "pad bit 7"
    };

    logic [7:0]  win [SPAN];
    logic [17:0] path_seen;
    logic [18:0] cmd_seen;
    logic        cmd_kind;
    logic [7:0]  verdicts_due [$];
    int          mismatches = 0;

    task automatic report(input string what, input logic [7:0] want, input logic [7:0] got);
        $display("[%0t] %s: expected %0h, got %0h", $time, what, want, got);
        mismatches++;
    endtask

    function automatic bit tail_is(input string p);
        int n;
        n = p.len();
        if (n == 0 || n > SPAN) return 1'b0;
        for (int i = 0; i < n; i++) begin
            if (win[SPAN - n + i] != p[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] judge_event();
        logic       dd;
        logic       sens;
        logic       hist;
        logic [7:0] v;
        // dd binary, an output file, and a zero or null source
        dd   = (|path_seen[1:0]) && cmd_seen[0] && (|cmd_seen[2:1]);
        // reader with a redirect, or any editor, against a system path
        sens = (((|path_seen[9:4]) && cmd_seen[3]) || (|path_seen[14:10]))
               && (|cmd_seen[16:4]);
        hist = (|path_seen[17:15]) && (|cmd_seen[18:17]);
        v          = '0;
        v[V_DD]    = dd;
        v[V_GROUP] = path_seen[2];
        v[V_SENS]  = sens;
        v[V_USER]  = path_seen[3];
        v[V_HIST]  = hist;
        v[V_ANY]   = dd | path_seen[2] | sens | path_seen[3] | hist;
        return v;
    endfunction

    task automatic clear_event();
        foreach (win[i]) win[i] = 8'h00;
        path_seen = '0;
        cmd_seen  = '0;
        cmd_kind  = 1'b0;
    endtask

    task automatic absorb(input action_t act, input logic [7:0] ch);
        logic kind;
        case (act)
            ACT_PATH, ACT_CMD: begin
                kind = (act == ACT_CMD);
                // zero the window whenever the string kind flips
                if (kind != cmd_kind) begin
                    foreach (win[i]) win[i] = 8'h00;
                    cmd_kind = kind;
                end
                for (int i = 0; i < SPAN - 1; i++) win[i] = win[i + 1];
                win[SPAN - 1] = ch;
                if (!kind) begin
                    foreach (path_pats[k]) if (tail_is(path_pats[k])) path_seen[k] = 1'b1;
                end else begin
                    foreach (cmd_pats[k]) if (tail_is(cmd_pats[k])) cmd_seen[k] = 1'b1;
                end
            end
            ACT_END: begin
                verdicts_due.push_back(judge_event());
                clear_event();
            end
            default: ;  // drop unused kind code
        endcase
    endtask

    always @(posedge clk or negedge rst_n) begin
        logic [7:0] want;
        if (!rst_n) begin
            clear_event();
            verdicts_due.delete();
            pending    <= 0;
            fail_count <= mismatches;
        end else begin
            // check the result word first so it can only match an earlier event
            if (m_tvalid && m_tready) begin
                if (verdicts_due.size() == 0) begin
                    report("result with no event pending", 8'h00, m_tdata);
                end else begin
                    want = verdicts_due.pop_front();
                    for (int b = 0; b < 8; b++) begin
                        if (m_tdata[b] !== want[b]) report(field_names[b], want[b], m_tdata[b]);
                    end
                end
            end
            if (s_tvalid && s_tready) absorb(action_t'(s_tuser), s_tdata);
            pending    <= verdicts_due.size();
            fail_count <= mismatches;
        end
    end

endmodule

### tb/tb.sv
// Testbench top for the signature matcher: clock, reset, event stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb;
    import psrm_pkg::*;

    localparam int WORD_TARGET  = 1100;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int NPF          = 24;
    localparam int NCF          = 27;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;  // [7:0] char_byte
    logic [1:0] s_tuser  = 2'd0;   // [1:0] action
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [0] dd, [1] group, [2] sensitive, [3] user,
                                   // [4] history, [5] any, [7:6] zero
    int fail_count;
    int pending;

    int words_sent = 0;
    int burst_left = 0;
    int rdy_mode   = 0;
    int rdy_left   = 0;
    int cycles     = 0;

    // Path fragments: the first 18 follow the matcher's path pattern order,
    // the rest are near misses and common prefixes.
    string path_frags [NPF] = '{
        "/bin/dd", "/usr/bin/dd", "/groupdel", "/userdel",
        "/cat", "/echo", "/grep", "/head", "/more", "/tail",
        "/emacs", "/nano", "/sed", "/vi", "/vim",
        "/rm", "/unlink", "/shred",
        "/usr", "/bin/", "/d", "/grou", "/e", "/sbin"
    };

    // Command-line fragments: the first 19 follow the command pattern order.
    string cmd_frags [NCF] = '{
        "of=", "if=/dev/zero", "if=/dev/null", ">",
        "/bin/login", "/bin/passwd", "/boot/", "/etc/*.conf", "/etc/cron.",
        "/etc/crontab", "/etc/hosts", "/etc/init.d", "/etc/sudoers",
        "/opt/bin/", "/sbin", "/usr/bin/", "/usr/local/bin/",
        {"/.bash", "_history"}, {"/.zsh", "_history"},
        " ", "-rf ", "of", "if=/dev/", "/etc/", {"bash", "_history"}, "/dev/sda", "/etc/cron"
    };

    process_signature_rule_matcher_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    rule_verdict_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Guard against a hung handshake.
    always @(posedge clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Receiver: switch at random among stall patterns whenever a run ends.
    // Mode 0 never stalls, mode 1 is a coin toss, mode 2 stalls mostly,
    // mode 3 toggles in runs set by bit 2 of the run counter.
    always @(posedge clk) begin
        if (rdy_left == 0) begin
            rdy_mode = $urandom_range(0, 3);
            rdy_left = $urandom_range(8, 80);
        end
        rdy_left--;
        case (rdy_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 4) == 0);
            default: m_tready <= rdy_left[2];
        endcase
    end

    // Offer one word and hold it until taken. Open each burst with an idle gap,
    // with junk on the data lines while idle.
    task automatic put_word(input action_t act, input logic [7:0] ch);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            s_tuser  <= 2'($urandom_range(0, 3));
            s_tdata  <= 8'($urandom_range(0, 255));
            repeat (($urandom_range(0, 7) == 0) ? $urandom_range(8, 24)
                                                : $urandom_range(1, 4)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 30);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= ch;
        do @(posedge clk); while (!s_tready);
        burst_left--;
        if (act != ACT_NONE) words_sent++;
    endtask

    task automatic send_text(input action_t act, input string s);
        for (int i = 0; i < s.len(); i++) put_word(act, s[i]);
    endtask

    // Send fragments back to back, now and then with a stray byte or a
    // dropped word between them.
    task automatic send_parts(input action_t act, input string parts [$]);
        foreach (parts[k]) begin
            if ($urandom_range(0, 3) == 0)
                put_word(act, ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 19) == 0) put_word(ACT_NONE, 8'($urandom_range(0, 255)));
            send_text(act, parts[k]);
        end
    endtask

    // Hold off the sender until every result word has been taken.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Build one event, half the time aimed at one rule, with random extra fragments.
    task automatic random_event();
        string path_parts [$];
        string cmd_parts [$];
        int    pick;
        pick = $urandom_range(0, 11);
        case (pick)
            0: begin  // dd overwrite
                path_parts.push_back(path_frags[$urandom_range(0, 1)]);
                cmd_parts.push_back(cmd_frags[0]);
                cmd_parts.push_back(cmd_frags[$urandom_range(1, 2)]);
            end
            1: path_parts.push_back(path_frags[2]);
            2: path_parts.push_back(path_frags[3]);
            3: begin  // reader redirected onto a system path
                path_parts.push_back(path_frags[$urandom_range(4, 9)]);
                cmd_parts.push_back(cmd_frags[3]);
                cmd_parts.push_back(cmd_frags[$urandom_range(4, 16)]);
            end
            4: begin  // editor on a system path
                path_parts.push_back(path_frags[$urandom_range(10, 14)]);
                cmd_parts.push_back(cmd_frags[$urandom_range(4, 16)]);
            end
            5: begin  // remover on a history file
                path_parts.push_back(path_frags[$urandom_range(15, 17)]);
                cmd_parts.push_back(cmd_frags[$urandom_range(17, 18)]);
            end
            10, 11: begin  // broken sequence: raw words of any kind
                repeat ($urandom_range(1, 40))
                    put_word(action_t'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
        repeat ($urandom_range(0, 2))
            path_parts.insert($urandom_range(0, path_parts.size()),
                              path_frags[$urandom_range(0, NPF - 1)]);
        repeat ($urandom_range(0, 3))
            cmd_parts.insert($urandom_range(0, cmd_parts.size()),
                             cmd_frags[$urandom_range(0, NCF - 1)]);
        send_parts(ACT_PATH, path_parts);
        send_parts(ACT_CMD, cmd_parts);
        // flip back to path bytes after the command line now and then
        if ($urandom_range(0, 9) == 0) send_text(ACT_PATH, path_frags[$urandom_range(0, NPF - 1)]);
        put_word(ACT_END, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: an empty event, a dropped word, an editor event with a
        // zero byte after the match, and a bare group deletion.
        put_word(ACT_END, 8'h00);
        put_word(ACT_NONE, 8'hFF);
        send_text(ACT_PATH, "/vi");
        put_word(ACT_PATH, 8'h00);
        send_text(ACT_CMD, "/sbin");
        put_word(ACT_END, 8'hFF);
        send_text(ACT_PATH, "/groupdel");
        put_word(ACT_CMD, 8'hFF);
        put_word(ACT_END, 8'h5A);
        wait_drained();

        // Random events until enough words have gone through.
        while (words_sent < WORD_TARGET) begin
            random_event();
            if ($urandom_range(0, 11) == 0) wait_drained();
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
